// File: hw/rtl/ssmg_pkg.sv
// Shared types, codes and helpers for the sorted-set minimum-gap block.
package ssmg_pkg;

    localparam int VALUE_W = 64;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_FULL     = 2'd1,
        ST_DUP      = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef struct packed {
        logic               command;
        logic [VALUE_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_W-1:0] min_gap;
        logic               has_gap;
        t_status            status;
    } t_out_item;

    typedef enum logic [2:0] {
        CELL_HOLD = 3'd0,
        CELL_CMP  = 3'd1,
        CELL_INS  = 3'd2,
        CELL_REM  = 3'd3,
        CELL_GAP  = 3'd4
    } t_cell_op;

    typedef struct packed {
        t_cell_op           op;
        logic [VALUE_W-1:0] key;
    } t_cell_ctrl;

    typedef struct packed {
        logic               vld;
        logic [VALUE_W-1:0] val;
    } t_gap;

    typedef enum logic [2:0] {
        S_IDLE  = 3'd0,
        S_CMP   = 3'd1,
        S_SHIFT = 3'd2,
        S_GAP   = 3'd3,
        S_TREE  = 3'd4,
        S_DONE  = 3'd5
    } t_state;

    // smaller of two gaps, ignoring invalid ones
    function automatic t_gap gap_min(t_gap a, t_gap b);
        t_gap r;
        if (!a.vld) begin
            r = b;
        end else if (!b.vld) begin
            r = a;
        end else if (b.val < a.val) begin
            r = b;
        end else begin
            r = a;
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/sorted_set_min_adjacent_gap_core.sv
// Sorted set of distinct 64-bit values with the smallest neighbour gap reported per request.
// Values sit in ascending order in a chain of CAPACITY cells. A request is taken when the
// block is idle; it then compares its value in every cell, shifts the chain (insert opens a
// hole, remove closes one), forms each neighbour difference, passes through the registered
// minimum tree and is loaded into the output register. The input is ready again only once
// the result is loaded, so a new request is never taken while another is in flight. The next
// one is taken while the result still waits in the output register; a result not yet taken
// holds the following request in its final cycle. Status: done, full, duplicate ignored or
// not found; in every case the result reports the set as it stands after the request.
module sorted_set_min_adjacent_gap_core
    import ssmg_pkg::*;
#(
    parameter int CAPACITY = 64
)(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam int LEVELS = $clog2(CAPACITY);
    localparam int LVL_W  = $clog2(LEVELS + 1);

    t_state r_state;
    t_state n_state;

    logic [VALUE_W-1:0] r_key;
    logic               r_cmd;
    t_status            r_status;
    t_status            n_status;
    logic [LVL_W-1:0]   r_lvl;
    logic               r_out_vld;
    t_out_item          r_out;

    t_cell_ctrl w_ctrl;
    t_cell_op   w_op;
    logic       w_accept;
    logic       w_load_out;
    logic       w_present;
    logic       w_full;

    logic [VALUE_W-1:0] w_val [CAPACITY];
    logic [CAPACITY-1:0] w_vld;
    logic [CAPACITY-1:0] w_lt;
    logic [CAPACITY-1:0] w_eq;
    t_gap               w_gap [CAPACITY];
    t_gap               w_root;

    assign w_present = |w_eq;
    assign w_full    = w_vld[CAPACITY-1];

    always_comb begin
        n_status = ST_DONE;
        if (r_cmd == CMD_INSERT) begin
            if (w_present) begin
                n_status = ST_DUP;
            end else if (w_full) begin
                n_status = ST_FULL;
            end
        end else if (!w_present) begin
            n_status = ST_NOTFOUND;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CMP;
                end
            end
            S_CMP:   n_state = S_SHIFT;
            S_SHIFT: n_state = S_GAP;
            S_GAP:   n_state = S_TREE;
            S_TREE: begin
                if (r_lvl == LVL_W'(LEVELS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_vld || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        w_accept   = 1'b0;
        w_load_out = 1'b0;
        w_op       = CELL_HOLD;
        case (r_state)
            S_IDLE:  w_accept = i_in_valid;
            S_CMP:   w_op = CELL_CMP;
            S_SHIFT: begin
                if (n_status == ST_DONE) begin
                    w_op = (r_cmd == CMD_INSERT) ? CELL_INS : CELL_REM;
                end
            end
            S_GAP:   w_op = CELL_GAP;
            S_DONE:  w_load_out = !r_out_vld || i_out_ready;
            default: begin
            end
        endcase
    end

    assign w_ctrl.op  = w_op;
    assign w_ctrl.key = r_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_lvl     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_GAP) begin
                r_lvl <= '0;
            end else if (r_state == S_TREE) begin
                r_lvl <= r_lvl + LVL_W'(1);
            end
            if (w_load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key <= i_in_data.value;
            r_cmd <= i_in_data.command;
        end
        if (r_state == S_SHIFT) begin
            r_status <= n_status;
        end
        if (w_load_out) begin
            r_out.min_gap <= w_root.vld ? w_root.val : '0;
            r_out.has_gap <= w_root.vld;
            r_out.status  <= r_status;
        end
    end

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [VALUE_W-1:0] w_left_val;
        logic               w_left_vld;
        logic               w_left_lt;
        logic [VALUE_W-1:0] w_right_val;
        logic               w_right_vld;

        if (k == 0) begin : g_first
            // nothing to the left: every held value there counts as smaller
            assign w_left_val = '0;
            assign w_left_vld = 1'b0;
            assign w_left_lt  = 1'b1;
        end else begin : g_mid
            assign w_left_val = w_val[k-1];
            assign w_left_vld = w_vld[k-1];
            assign w_left_lt  = w_lt[k-1];
        end

        if (k == CAPACITY - 1) begin : g_last
            assign w_right_val = '0;
            assign w_right_vld = 1'b0;
        end else begin : g_inner
            assign w_right_val = w_val[k+1];
            assign w_right_vld = w_vld[k+1];
        end

        ssmg_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (w_ctrl),
            .i_left_val  (w_left_val),
            .i_left_vld  (w_left_vld),
            .i_left_lt   (w_left_lt),
            .i_right_val (w_right_val),
            .i_right_vld (w_right_vld),
            .o_val       (w_val[k]),
            .o_vld       (w_vld[k]),
            .o_lt        (w_lt[k]),
            .o_eq        (w_eq[k]),
            .o_gap       (w_gap[k])
        );
    end

    ssmg_min_tree #(
        .LEAVES (CAPACITY)
    ) u_tree (
        .i_clk  (i_clk),
        .i_leaf (w_gap),
        .o_root (w_root)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// File: hw/rtl/ssmg_cell.sv
// One cell of the sorted chain: holds one value, compares, shifts and forms its gap.
module ssmg_cell
    import ssmg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cell_ctrl         i_ctrl,
    input  logic [VALUE_W-1:0] i_left_val,
    input  logic               i_left_vld,
    input  logic               i_left_lt,
    input  logic [VALUE_W-1:0] i_right_val,
    input  logic               i_right_vld,
    output logic [VALUE_W-1:0] o_val,
    output logic               o_vld,
    output logic               o_lt,
    output logic               o_eq,
    output t_gap               o_gap
);

    logic [VALUE_W-1:0] r_val;
    logic               r_vld;
    logic               r_lt;
    logic               r_eq;
    logic [VALUE_W-1:0] r_gap_val;
    logic               r_gap_vld;

    // payload
    always_ff @(posedge i_clk) begin
        case (i_ctrl.op)
            CELL_INS: begin
                if (!r_lt) begin
                    r_val <= i_left_lt ? i_ctrl.key : i_left_val;
                end
            end
            CELL_REM: begin
                if (!r_lt) begin
                    r_val <= i_right_val;
                end
            end
            CELL_GAP: begin
                r_gap_val <= r_val - i_left_val;
            end
            default: begin
            end
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= 1'b0;
            r_lt      <= 1'b0;
            r_eq      <= 1'b0;
            r_gap_vld <= 1'b0;
        end else begin
            case (i_ctrl.op)
                CELL_CMP: begin
                    r_lt <= r_vld && (r_val < i_ctrl.key);
                    r_eq <= r_vld && (r_val == i_ctrl.key);
                end
                CELL_INS: begin
                    // new key lands in the first cell not below it; the rest move right
                    if (!r_lt) begin
                        r_vld <= i_left_lt ? 1'b1 : i_left_vld;
                    end
                end
                CELL_REM: begin
                    if (!r_lt) begin
                        r_vld <= i_right_vld;
                    end
                end
                CELL_GAP: begin
                    r_gap_vld <= r_vld && i_left_vld;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_val     = r_val;
    assign o_vld     = r_vld;
    assign o_lt      = r_lt;
    assign o_eq      = r_eq;
    assign o_gap.vld = r_gap_vld;
    assign o_gap.val = r_gap_val;

endmodule

// File: hw/rtl/ssmg_min_tree.sv
// Registered binary minimum tree over the cell gaps, one level per cycle.
module ssmg_min_tree
    import ssmg_pkg::*;
#(
    parameter int LEAVES = 64
)(
    input  logic i_clk,
    input  t_gap i_leaf [LEAVES],
    output t_gap o_root
);

    localparam int LEVELS = $clog2(LEAVES);
    localparam int PADDED = 1 << LEVELS;

    localparam t_gap GAP_NONE = '{vld: 1'b0, val: '0};

    // heap order: node i takes nodes 2i and 2i+1, leaves sit at PADDED..2*PADDED-1
    t_gap r_node [1:PADDED-1];

    for (genvar i = 1; i < PADDED; i++) begin : g_node
        t_gap w_a;
        t_gap w_b;

        if (2 * i >= PADDED) begin : g_leaf
            if (2 * i - PADDED < LEAVES) begin : g_a
                assign w_a = i_leaf[2 * i - PADDED];
            end else begin : g_a_pad
                assign w_a = GAP_NONE;
            end
            if (2 * i + 1 - PADDED < LEAVES) begin : g_b
                assign w_b = i_leaf[2 * i + 1 - PADDED];
            end else begin : g_b_pad
                assign w_b = GAP_NONE;
            end
        end else begin : g_inner
            assign w_a = r_node[2 * i];
            assign w_b = r_node[2 * i + 1];
        end

        always_ff @(posedge i_clk) begin
            r_node[i] <= gap_min(w_a, w_b);
        end
    end

    assign o_root = r_node[1];

endmodule

// File: dv/sorted_set_min_adjacent_gap_core_tb.sv
// Self-checking testbench for the sorted-set minimum-gap core: directed table, then random traffic.
`timescale 1ns / 100ps

module sorted_set_min_adjacent_gap_core_tb;
    import ssmg_pkg::*;

    localparam int CAP         = 64;
    localparam int TOTAL_REQS  = 1650;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_AT     = 400;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_AT    = 1200;
    localparam int IDLE_PCT    = 38;
    localparam logic [VALUE_W-1:0] MAXV = '1;
    localparam logic [VALUE_W-1:0] MSB  = {1'b1, {(VALUE_W-1){1'b0}}};

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } t_mix;

    typedef struct {
        t_cmd               cmd;
        logic [VALUE_W-1:0] value;
        bit                 typed;
        t_out_item          exp_rep;
    } t_dir_row;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    t_in_item  req_data = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    t_out_item rsp_data;

    // typed expectation travelling with the request on offer
    bit        row_typed = 1'b0;
    t_out_item row_exp = '0;

    logic [VALUE_W-1:0] held[$];
    t_out_item          gap_report_q[$];
    t_dir_row           dir_rows[$];

    int sent_cnt = 0;
    int fails = 0;
    int stall_cycles = 0;

    sorted_set_min_adjacent_gap_core #(
        .CAPACITY(CAP)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (req_valid),
        .o_in_ready (req_ready),
        .i_in_data  (req_data),
        .o_out_valid(rsp_valid),
        .i_out_ready(rsp_ready),
        .o_out_data (rsp_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit no_idle_window();
        return sent_cnt >= 700 && sent_cnt < 1000;
    endfunction

    // applies one request to the shadow set and returns the gap report after it
    function automatic t_out_item apply_set_request(t_in_item req);
        t_out_item          rep;
        int                 pos;
        int                 i;
        bit                 present;
        logic [VALUE_W-1:0] d;
        pos = 0;
        while (pos < held.size() && held[pos] < req.value) pos++;
        present = (pos < held.size()) && (held[pos] == req.value);
        rep = '0;
        rep.status = ST_DONE;
        if (req.command == CMD_INSERT) begin
            if (present) begin
                rep.status = ST_DUP;
            end else if (held.size() >= CAP) begin
                rep.status = ST_FULL;
            end else begin
                held.insert(pos, req.value);
            end
        end else if (!present) begin
            rep.status = ST_NOTFOUND;
        end else begin
            held.delete(pos);
        end
        for (i = 1; i < held.size(); i++) begin
            d = held[i] - held[i-1];
            if (!rep.has_gap || d < rep.min_gap) begin
                rep.min_gap = d;
                rep.has_gap = 1'b1;
            end
        end
        return rep;
    endfunction

    function automatic t_out_item report(logic [VALUE_W-1:0] gap, logic has, t_status st);
        t_out_item r;
        r.min_gap = gap;
        r.has_gap = has;
        r.status  = st;
        return r;
    endfunction

    task automatic add_row(t_cmd cmd, logic [VALUE_W-1:0] value, bit typed, t_out_item exp_rep);
        t_dir_row row;
        row.cmd     = cmd;
        row.value   = value;
        row.typed   = typed;
        row.exp_rep = exp_rep;
        dir_rows.push_back(row);
    endtask

    // values biased towards held ones, their neighbours and the range ends
    function automatic logic [VALUE_W-1:0] pick_value(bit for_remove);
        int                 r;
        logic [VALUE_W-1:0] base;
        r = $urandom_range(99);
        if (held.size() != 0) begin
            base = held[$urandom_range(held.size() - 1)];
        end else begin
            base = {$urandom, $urandom};
        end
        if (r < (for_remove ? 75 : 15)) begin
            return base;
        end else if (r < (for_remove ? 85 : 35)) begin
            if ($urandom_range(1)) return base + VALUE_W'($urandom_range(1, 4));
            return base - VALUE_W'($urandom_range(1, 4));
        end else if (r < (for_remove ? 90 : 45)) begin
            case ($urandom_range(3))
                0: return VALUE_W'($urandom_range(0, 15));
                1: return MAXV - VALUE_W'($urandom_range(0, 15));
                2: return MSB - VALUE_W'($urandom_range(0, 3));
                default: return MSB + VALUE_W'($urandom_range(0, 3));
            endcase
        end
        return {$urandom, $urandom};
    endfunction

    task automatic offer_request(t_in_item it, bit typed, t_out_item exp_rep);
        while (!no_idle_window() && $urandom_range(99) < IDLE_PCT) begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= it;
        row_typed <= typed;
        row_exp   <= exp_rep;
        do @(posedge clk); while (!req_ready);
        sent_cnt++;
        @(negedge clk);
    endtask

    task automatic check_report(t_out_item got);
        t_out_item want;
        if (gap_report_q.size() == 0) begin
            $error("unexpected result: min_gap %h has_gap %b status %0d",
                   got.min_gap, got.has_gap, got.status);
            fails++;
            return;
        end
        want = gap_report_q.pop_front();
        if (got.min_gap !== want.min_gap) begin
            $error("min_gap: expected %h, got %h", want.min_gap, got.min_gap);
            fails++;
        end
        if (got.has_gap !== want.has_gap) begin
            $error("has_gap: expected %b, got %b", want.has_gap, got.has_gap);
            fails++;
        end
        if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fails++;
        end
    endtask

    // predict on acceptance, check on delivery, and watch for a stalled block
    always @(posedge clk) begin : monitor
        t_out_item predicted;
        if (rst_n) begin
            if (req_valid && req_ready) begin
                predicted = apply_set_request(req_data);
                if (row_typed) predicted = row_exp;
                gap_report_q.push_back(predicted);
            end
            if (rsp_valid && rsp_ready) check_report(rsp_data);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // result side: random back-pressure, one long hold-off so the input stalls
    initial begin : receiver
        bit hold_done;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (!hold_done && sent_cnt >= HOLD_AT) begin
                hold_done = 1'b1;
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            rsp_ready <= no_idle_window() || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial begin : sender
        t_in_item  it;
        t_mix      mix;
        int        len;
        int        ins_pct;
        bit        first;
        t_out_item none;
        none = '0;

        add_row(CMD_REMOVE, 64'd5,     1, report('0, 1'b0, ST_NOTFOUND));
        add_row(CMD_INSERT, 64'd0,     1, report('0, 1'b0, ST_DONE));
        add_row(CMD_INSERT, 64'd0,     1, report('0, 1'b0, ST_DUP));
        add_row(CMD_REMOVE, 64'd7,     1, report('0, 1'b0, ST_NOTFOUND));
        add_row(CMD_INSERT, MAXV,      1, report(MAXV, 1'b1, ST_DONE));
        add_row(CMD_INSERT, 64'd1,     1, report(64'd1, 1'b1, ST_DONE));
        add_row(CMD_INSERT, MAXV - 1,  1, report(64'd1, 1'b1, ST_DONE));
        add_row(CMD_REMOVE, 64'd1,     1, report(64'd1, 1'b1, ST_DONE));
        add_row(CMD_REMOVE, MAXV - 1,  1, report(MAXV, 1'b1, ST_DONE));
        add_row(CMD_INSERT, MAXV,      1, report(MAXV, 1'b1, ST_DUP));
        add_row(CMD_REMOVE, 64'd0,     1, report('0, 1'b0, ST_DONE));
        add_row(CMD_REMOVE, MAXV,      1, report('0, 1'b0, ST_DONE));
        add_row(CMD_INSERT, MSB,       1, report('0, 1'b0, ST_DONE));
        add_row(CMD_INSERT, MSB - 1,   1, report(64'd1, 1'b1, ST_DONE));
        add_row(CMD_INSERT, 64'h5555_5555_5555_5555, 0, none);
        add_row(CMD_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 0, none);
        add_row(CMD_REMOVE, MSB,       0, none);
        add_row(CMD_REMOVE, 64'h1234,  0, none);
        add_row(CMD_INSERT, 64'h5555_5555_5555_5556, 0, none);
        add_row(CMD_REMOVE, MSB - 1,   0, none);
        add_row(CMD_REMOVE, 64'h5555_5555_5555_5555, 0, none);
        add_row(CMD_REMOVE, 64'h5555_5555_5555_5556, 0, none);
        add_row(CMD_REMOVE, 64'hAAAA_AAAA_AAAA_AAAA, 1, report('0, 1'b0, ST_DONE));

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            it.command = dir_rows[k].cmd;
            it.value   = dir_rows[k].value;
            offer_request(it, dir_rows[k].typed, dir_rows[k].exp_rep);
        end

        // random phases; the first one fills the store so the full case is reached early
        first = 1'b1;
        while (sent_cnt < TOTAL_REQS) begin
            mix   = first ? MIX_FILL : t_mix'($urandom_range(2));
            first = 1'b0;
            len   = $urandom_range(40, 150);
            case (mix)
                MIX_FILL:  ins_pct = 90;
                MIX_DRAIN: ins_pct = 15;
                default:   ins_pct = 50;
            endcase
            repeat (len) begin
                if (sent_cnt >= TOTAL_REQS) break;
                if (sent_cnt == DRAIN_AT) begin
                    // let the block empty out completely before going on
                    req_valid <= 1'b0;
                    do @(negedge clk); while (gap_report_q.size() != 0);
                end
                if ($urandom_range(99) < ins_pct) begin
                    it.command = CMD_INSERT;
                    it.value   = pick_value(1'b0);
                end else begin
                    it.command = CMD_REMOVE;
                    it.value   = pick_value(1'b1);
                end
                offer_request(it, 1'b0, none);
            end
        end

        req_valid <= 1'b0;
        do @(negedge clk); while (gap_report_q.size() != 0);
        repeat (20) @(negedge clk);
        if (fails == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
